// ----- rtl/core/cdq_pkg.sv -----
// Shared types, constants and helper functions for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

  // Ring geometry.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [OP_W-1:0]          op_t;
  typedef logic [STAT_W-1:0]        stat_t;
  typedef logic [FILL_W-1:0]        fill_t;
  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Operation codes.
  localparam op_t OP_PUSH_FRONT = 2'd0;
  localparam op_t OP_PUSH_REAR  = 2'd1;
  localparam op_t OP_POP_FRONT  = 2'd2;
  localparam op_t OP_POP_REAR   = 2'd3;

  // Status codes.
  localparam stat_t ST_DONE  = 2'd0;
  localparam stat_t ST_FULL  = 2'd1;
  localparam stat_t ST_EMPTY = 2'd2;

  localparam ptr_t PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam cnt_t CNT_DEPTH = CNT_W'(DEPTH);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted input item
    logic exec;  // perform the operation and access the ring store
  } cmd_t;

  // Advance a pointer by one slot, wrapping past the last slot.
  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    r = (p == PTR_LAST) ? '0 : p + ptr_t'(1);
    return r;
  endfunction

  // Move a pointer back by one slot, wrapping below slot zero.
  function automatic ptr_t ptr_dec(ptr_t p);
    ptr_t r;
    r = (p == '0) ? PTR_LAST : p - ptr_t'(1);
    return r;
  endfunction

  // Fit the entry count into the reported fill count width.
  function automatic fill_t fill_of(cnt_t c);
    logic [CNT_W+FILL_W-1:0] wide;
    wide = {{FILL_W{1'b0}}, c};
    return wide[FILL_W-1:0];
  endfunction

endpackage

// ----- rtl/core/cdq_in_if.sv -----
// Request channel interface: operation code and value with valid/ready.
`timescale 1ns / 1ps

interface cdq_in_if;

  logic            valid;
  logic            ready;
  cdq_pkg::op_t    opcode;
  cdq_pkg::data_t  item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);

endinterface

// ----- rtl/core/cdq_out_if.sv -----
// Result channel interface: popped value, status and fill flags with valid/ready.
`timescale 1ns / 1ps

interface cdq_out_if;

  logic            valid;
  logic            ready;
  cdq_pkg::data_t  popped_value;
  cdq_pkg::stat_t  status;
  cdq_pkg::fill_t  fill_count;
  logic            now_empty;
  logic            now_full;

  modport source (output valid, output popped_value, output status,
                  output fill_count, output now_empty, output now_full,
                  input ready);
  modport sink   (input valid, input popped_value, input status,
                  input fill_count, input now_empty, input now_full,
                  output ready);

endinterface

// ----- rtl/core/cdq_ctrl.sv -----
// Controller state machine that sequences one deque operation at a time.
`timescale 1ns / 1ps

module cdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdq_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshake and datapath commands.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign cmd_o.load  = in_ready_o && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);

endmodule

// ----- rtl/core/cdq_datapath.sv -----
// Datapath: pointers, entry count, ring store and result registers.
`timescale 1ns / 1ps

module cdq_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cdq_pkg::cmd_t  cmd_i,
  input  cdq_pkg::op_t   opcode_i,
  input  cdq_pkg::data_t item_value_i,
  output cdq_pkg::data_t popped_value_o,
  output cdq_pkg::stat_t status_o,
  output cdq_pkg::fill_t fill_count_o,
  output logic           now_empty_o,
  output logic           now_full_o
);

  // Ring store; contents are undefined until written.
  cdq_pkg::data_t mem_q [cdq_pkg::DEPTH];

  cdq_pkg::op_t   op_q;
  cdq_pkg::data_t val_q;
  cdq_pkg::ptr_t  head_q, head_d;
  cdq_pkg::ptr_t  tail_q, tail_d;
  cdq_pkg::cnt_t  count_q, count_d;
  cdq_pkg::stat_t status_q, status_d;
  logic           pop_ok_q, pop_ok_d;
  cdq_pkg::data_t rd_q;

  logic           full, empty;
  logic           wr_en, rd_en;
  cdq_pkg::ptr_t  addr;

  assign full  = (count_q == cdq_pkg::CNT_DEPTH);
  assign empty = (count_q == '0);

  // Operation decode: pointer moves, store address and status.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = cdq_pkg::ST_DONE;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    addr     = head_q;
    case (op_q)
      cdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_d = cdq_pkg::ST_FULL;
        end else begin
          head_d  = cdq_pkg::ptr_dec(head_q);
          addr    = head_d;
          wr_en   = 1'b1;
          count_d = count_q + cdq_pkg::cnt_t'(1);
        end
      end
      cdq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          status_d = cdq_pkg::ST_FULL;
        end else begin
          addr    = tail_q;
          tail_d  = cdq_pkg::ptr_inc(tail_q);
          wr_en   = 1'b1;
          count_d = count_q + cdq_pkg::cnt_t'(1);
        end
      end
      cdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_d = cdq_pkg::ST_EMPTY;
        end else begin
          addr     = head_q;
          head_d   = cdq_pkg::ptr_inc(head_q);
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          count_d  = count_q - cdq_pkg::cnt_t'(1);
        end
      end
      cdq_pkg::OP_POP_REAR: begin
        if (empty) begin
          status_d = cdq_pkg::ST_EMPTY;
        end else begin
          tail_d   = cdq_pkg::ptr_dec(tail_q);
          addr     = tail_d;
          rd_en    = 1'b1;
          pop_ok_d = 1'b1;
          count_d  = count_q - cdq_pkg::cnt_t'(1);
        end
      end
      default: begin
        status_d = cdq_pkg::ST_DONE;
      end
    endcase
  end

  // Input capture; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= item_value_i;
    end
  end

  // Pointers, count and result status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      status_q <= cdq_pkg::ST_DONE;
      pop_ok_q <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  // Ring store with one write or one registered read per operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[addr] <= val_q;
    end
    if (cmd_i.exec && rd_en) begin
      rd_q <= mem_q[addr];
    end
  end

  // Result fields.
  assign popped_value_o = pop_ok_q ? rd_q : '0;
  assign status_o       = status_q;
  assign fill_count_o   = cdq_pkg::fill_of(count_q);
  assign now_empty_o    = (count_q == '0);
  assign now_full_o     = (count_q == cdq_pkg::CNT_DEPTH);

endmodule

// ----- rtl/core/circular_deque.sv -----
// Top level of the circular deque: controller plus datapath on two channels.
`timescale 1ns / 1ps

// Double-ended queue of cdq_pkg::DEPTH 32-bit entries held in a ring store.
// Each request on in_i pushes at the front or rear or pops from the front or
// rear, and yields exactly one result on out_o with the popped value (zero
// unless a pop succeeded), a status code (done, refused full, refused empty),
// the fill count and the empty and full flags after the operation. Requests
// are handled one at a time: after a request transfer, the controller passes
// through an execute state, in which the operation accesses the ring store,
// then a response state, in which the result is offered from the store's
// registered read port. The next request is taken only after the result
// transfer, once the controller is back in idle, so no new request is
// taken while the result waits for out_o.
// The ring store has no reset and needs no clearing pass; the pointers and
// the count come out of reset at zero.
module circular_deque (
  input  logic     clk_i,
  input  logic     rst_ni,
  cdq_in_if.sink   in_i,
  cdq_out_if.source out_o
);

  cdq_pkg::cmd_t cmd;

  // Sequencing of requests and results.
  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Storage and operation logic.
  cdq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (in_i.opcode),
    .item_value_i   (in_i.item_value),
    .popped_value_o (out_o.popped_value),
    .status_o       (out_o.status),
    .fill_count_o   (out_o.fill_count),
    .now_empty_o    (out_o.now_empty),
    .now_full_o     (out_o.now_full)
  );

endmodule
